// ----- rtl/core/gws_pkg.sv -----
// Shared types, codes and constants of the grid word search block.
package gws_pkg;

  // Default sizes of the grid and the word store.
  localparam int MaxRowsDefault = 64;
  localparam int MaxColsDefault = 64;
  localparam int MaxWordDefault = 32;

  // Reset values of the region bounds.
  localparam logic [6:0] RowEndReset = 7'd64;
  localparam logic [6:0] ColEndReset = 7'd64;

  // Request commands.
  typedef enum logic [1:0] {
    CMD_GRID   = 2'd0,
    CMD_WORD   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ROW_START = 2'd0,
    CFG_ROW_END   = 2'd1,
    CFG_COL_START = 2'd2,
    CFG_COL_END   = 2'd3
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CELL,
    S_CELL_CMP,
    S_PROBE,
    S_PROBE_CMP,
    S_DONE
  } state_e;

  // Input request payload.
  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic [7:0] char_value;
    logic [4:0] word_pos;
    logic [5:0] word_len;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic       found;
    logic [5:0] match_row;
    logic [5:0] match_col;
  } out_item_t;

  // Configuration write payload.
  typedef struct packed {
    logic [1:0] index;
    logic [6:0] data;
  } cfg_req_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_grid;
    logic wr_word;
    logic load_search;
    logic rd_cell;
    logic rd_probe;
    logic dir_first;
    logic dir_next;
    logic step;
    logic next_col;
    logic next_row;
    logic set_found;
    logic load_result;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic match;
    logic len_one;
    logic last_k;
    logic last_dir;
    logic probe_oob;
    logic col_last;
    logic row_last;
    logic out_busy;
  } dp_status_t;

  // Row step of each direction: left, up, down, right.
  function automatic logic signed [1:0] step_row(input logic [1:0] dir);
    logic signed [1:0] s;
    unique case (dir)
      2'd1:    s = -2'sd1;
      2'd2:    s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

  // Column step of each direction: left, up, down, right.
  function automatic logic signed [1:0] step_col(input logic [1:0] dir);
    logic signed [1:0] s;
    unique case (dir)
      2'd0:    s = -2'sd1;
      2'd3:    s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/gws_stream_if.sv -----
// Valid/ready channel carrying one payload per request.
interface gws_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/gws_ctrl.sv -----
// Search sequencer: walks start cells, directions and word characters.
module gws_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  input  logic [1:0]             req_cmd_i,
  output logic                   req_ready_o,
  input  gws_pkg::dp_status_t    sts_i,
  output gws_pkg::ctrl_cmd_t     cmd_o
);

  gws_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gws_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    logic adv;
    logic ndir;
    adv         = 1'b0;
    ndir        = 1'b0;
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;

    unique case (state_q)
      gws_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (req_cmd_i)
            gws_pkg::CMD_GRID: cmd_o.wr_grid = 1'b1;
            gws_pkg::CMD_WORD: cmd_o.wr_word = 1'b1;
            gws_pkg::CMD_SEARCH: begin
              cmd_o.load_search = 1'b1;
              state_d           = gws_pkg::S_START;
            end
            default: ;
          endcase
        end
      end
      gws_pkg::S_START: begin
        state_d = sts_i.empty ? gws_pkg::S_DONE : gws_pkg::S_CELL;
      end
      gws_pkg::S_CELL: begin
        cmd_o.rd_cell = 1'b1;
        state_d       = gws_pkg::S_CELL_CMP;
      end
      gws_pkg::S_CELL_CMP: begin
        if (!sts_i.match) begin
          adv = 1'b1;
        end else if (sts_i.len_one) begin
          cmd_o.set_found = 1'b1;
          state_d         = gws_pkg::S_DONE;
        end else begin
          cmd_o.dir_first = 1'b1;
          state_d         = gws_pkg::S_PROBE;
        end
      end
      gws_pkg::S_PROBE: begin
        if (sts_i.probe_oob) begin
          ndir = 1'b1;
        end else begin
          cmd_o.rd_probe = 1'b1;
          state_d        = gws_pkg::S_PROBE_CMP;
        end
      end
      gws_pkg::S_PROBE_CMP: begin
        if (!sts_i.match) begin
          ndir = 1'b1;
        end else if (sts_i.last_k) begin
          cmd_o.set_found = 1'b1;
          state_d         = gws_pkg::S_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = gws_pkg::S_PROBE;
        end
      end
      gws_pkg::S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_result = 1'b1;
          state_d           = gws_pkg::S_IDLE;
        end
      end
      default: state_d = gws_pkg::S_IDLE;
    endcase

    // A failed direction moves to the next one, or to the next start cell.
    if (ndir) begin
      if (sts_i.last_dir) begin
        adv = 1'b1;
      end else begin
        cmd_o.dir_next = 1'b1;
        state_d        = gws_pkg::S_PROBE;
      end
    end

    // Move to the next start cell in row order, or finish without a match.
    if (adv) begin
      if (!sts_i.col_last) begin
        cmd_o.next_col = 1'b1;
        state_d        = gws_pkg::S_CELL;
      end else if (!sts_i.row_last) begin
        cmd_o.next_row = 1'b1;
        state_d        = gws_pkg::S_CELL;
      end else begin
        state_d = gws_pkg::S_DONE;
      end
    end
  end

endmodule

// ----- rtl/core/gws_dp.sv -----
// Datapath: grid and word stores, scan counters, bounds and result register.
module gws_dp #(
  parameter int MAX_ROWS = gws_pkg::MaxRowsDefault,
  parameter int MAX_COLS = gws_pkg::MaxColsDefault,
  parameter int MAX_WORD = gws_pkg::MaxWordDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gws_pkg::in_item_t    req_i,
  input  gws_pkg::ctrl_cmd_t   cmd_i,
  output gws_pkg::dp_status_t  sts_o,
  input  logic                 cfg_valid_i,
  input  gws_pkg::cfg_req_t    cfg_i,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output gws_pkg::out_item_t   rsp_o
);

  localparam int RowBits   = $clog2(MAX_ROWS + 1);
  localparam int ColBits   = $clog2(MAX_COLS + 1);
  localparam int RcBits    = (RowBits > ColBits) ? RowBits : ColBits;
  localparam int CW        = (RcBits > 7) ? RcBits : 7;
  localparam int GridDepth = MAX_ROWS * MAX_COLS;
  localparam int GAW       = (GridDepth > 1) ? $clog2(GridDepth) : 1;
  localparam int WAW       = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int LW        = $clog2(MAX_WORD + 1);

  // Configuration registers.
  logic [5:0] row_start_q, col_start_q;
  logic [6:0] row_end_q, col_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_start_q <= '0;
      row_end_q   <= gws_pkg::RowEndReset;
      col_start_q <= '0;
      col_end_q   <= gws_pkg::ColEndReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.index)
        gws_pkg::CFG_ROW_START: row_start_q <= cfg_i.data[5:0];
        gws_pkg::CFG_ROW_END:   row_end_q   <= cfg_i.data;
        gws_pkg::CFG_COL_START: col_start_q <= cfg_i.data[5:0];
        gws_pkg::CFG_COL_END:   col_end_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // End bounds clipped to the grid size.
  logic [CW-1:0] rb, cb, row_start_w, col_start_w;
  assign rb = (32'(row_end_q) < MAX_ROWS) ? CW'(row_end_q) : CW'(MAX_ROWS);
  assign cb = (32'(col_end_q) < MAX_COLS) ? CW'(col_end_q) : CW'(MAX_COLS);
  assign row_start_w = CW'(row_start_q);
  assign col_start_w = CW'(col_start_q);

  // Scan state: start cell, direction, path cell and character index.
  logic [CW-1:0]        row_q, col_q;
  logic signed [CW:0]   pr_q, pc_q;
  logic [1:0]           dir_q;
  logic [LW-1:0]        k_q, len_q;
  logic                 found_q;

  // Saturated word length of a search request.
  logic [LW-1:0] len_in;
  assign len_in = (32'(req_i.word_len) > MAX_WORD) ? LW'(MAX_WORD) : LW'(req_i.word_len);

  // Path start for a chosen direction, one step from the start cell.
  logic [1:0]         dir_sel;
  logic signed [CW:0] pr_first, pc_first;
  assign dir_sel  = cmd_i.dir_next ? dir_q + 2'd1 : 2'd0;
  assign pr_first = $signed({1'b0, row_q}) + (CW + 1)'(gws_pkg::step_row(dir_sel));
  assign pc_first = $signed({1'b0, col_q}) + (CW + 1)'(gws_pkg::step_col(dir_sel));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_search) begin
      len_q <= len_in;
      row_q <= row_start_w;
      col_q <= col_start_w;
    end else if (cmd_i.next_col) begin
      col_q <= col_q + CW'(1);
    end else if (cmd_i.next_row) begin
      row_q <= row_q + CW'(1);
      col_q <= col_start_w;
    end
    if (cmd_i.dir_first || cmd_i.dir_next) begin
      dir_q <= dir_sel;
      pr_q  <= pr_first;
      pc_q  <= pc_first;
      k_q   <= LW'(1);
    end else if (cmd_i.step) begin
      pr_q <= pr_q + (CW + 1)'(gws_pkg::step_row(dir_q));
      pc_q <= pc_q + (CW + 1)'(gws_pkg::step_col(dir_q));
      k_q  <= k_q + LW'(1);
    end
  end

  // Match flag of the running search.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load_search) begin
      found_q <= 1'b0;
    end else if (cmd_i.set_found) begin
      found_q <= 1'b1;
    end
  end

  // Grid write and read addresses, row-major.
  logic [CW-1:0]  rd_row, rd_col;
  logic [GAW-1:0] grid_waddr, grid_raddr;
  logic           grid_we, word_we;
  logic [WAW-1:0] word_raddr;

  assign rd_row     = cmd_i.rd_probe ? pr_q[CW-1:0] : row_q;
  assign rd_col     = cmd_i.rd_probe ? pc_q[CW-1:0] : col_q;
  assign grid_raddr = GAW'(32'(rd_row) * 32'(MAX_COLS) + 32'(rd_col));
  assign grid_waddr = GAW'(32'(req_i.cell_row) * 32'(MAX_COLS) + 32'(req_i.cell_col));
  assign grid_we    = cmd_i.wr_grid && (32'(req_i.cell_row) < MAX_ROWS)
                      && (32'(req_i.cell_col) < MAX_COLS);
  assign word_we    = cmd_i.wr_word && (32'(req_i.word_pos) < MAX_WORD);
  assign word_raddr = cmd_i.rd_probe ? k_q[WAW-1:0] : '0;

  // Grid store, one write and one registered read port.
  logic [7:0] grid_mem [GridDepth];
  logic [7:0] grid_rd_q;

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= req_i.char_value;
    end
    if (cmd_i.rd_cell || cmd_i.rd_probe) begin
      grid_rd_q <= grid_mem[grid_raddr];
    end
  end

  // Word store, one write and one registered read port.
  logic [7:0] word_mem [MAX_WORD];
  logic [7:0] word_rd_q;

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[WAW'(req_i.word_pos)] <= req_i.char_value;
    end
    if (cmd_i.rd_cell || cmd_i.rd_probe) begin
      word_rd_q <= word_mem[word_raddr];
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_result) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      rsp_o.found     <= found_q;
      rsp_o.match_row <= found_q ? row_q[5:0] : 6'd0;
      rsp_o.match_col <= found_q ? col_q[5:0] : 6'd0;
    end
  end

  assign rsp_valid_o = out_valid_q;

  // Status toward the controller.
  assign sts_o.empty     = (len_q == '0) || (row_start_w >= rb) || (col_start_w >= cb);
  assign sts_o.match     = (grid_rd_q == word_rd_q);
  assign sts_o.len_one   = (len_q == LW'(1));
  assign sts_o.last_k    = (k_q == len_q - LW'(1));
  assign sts_o.last_dir  = (dir_q == 2'd3);
  assign sts_o.probe_oob = pr_q[CW] || pc_q[CW] || (pr_q[CW-1:0] >= rb)
                           || (pc_q[CW-1:0] >= cb);
  assign sts_o.col_last  = (col_q + CW'(1) >= cb);
  assign sts_o.row_last  = (row_q + CW'(1) >= rb);
  assign sts_o.out_busy  = out_valid_q && !rsp_ready_i;

  // A path read only ever touches a cell inside the region.
  a_probe_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_probe |-> !sts_o.probe_oob)
    else $error("path read outside the region");

  // Path character index stays at least one and below the word length.
  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_probe |-> (k_q != '0) && (k_q < len_q))
    else $error("word index out of range");

  // A start cell read lies inside the region.
  a_cell_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_cell |-> (row_q < rb) && (col_q < cb))
    else $error("start cell outside the region");

  // A result is loaded only when the output slot is free.
  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_result |-> !out_valid_q || rsp_ready_i)
    else $error("result overwritten before it was taken");

endmodule

// ----- rtl/core/grid_word_search.sv -----
// Grid word search top level: grid and word writes, and four-direction searches.
// A grid or word write request is taken while idle and gives no result. A search passes
// a start state, then reads and compares the first character at each start cell and, per
// tried direction, each further character, leaving a direction once the path leaves the
// region. The result is registered once no earlier result is held; one request at a time.
// Reset clears the controller, the result register and the bounds; stores are unset.
module grid_word_search #(
  parameter int MAX_ROWS = gws_pkg::MaxRowsDefault,
  parameter int MAX_COLS = gws_pkg::MaxColsDefault,
  parameter int MAX_WORD = gws_pkg::MaxWordDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gws_stream_if.sink          req_i,
  gws_stream_if.source        rsp_o,
  gws_stream_if.sink          cfg_i
);

  gws_pkg::ctrl_cmd_t  cmd;
  gws_pkg::dp_status_t sts;
  gws_pkg::in_item_t   req_payload;
  gws_pkg::cfg_req_t   cfg_payload;
  gws_pkg::out_item_t  rsp_payload;
  logic                rsp_valid;

  assign req_payload   = req_i.payload;
  assign cfg_payload   = cfg_i.payload;
  assign cfg_i.ready   = 1'b1;
  assign rsp_o.valid   = rsp_valid;
  assign rsp_o.payload = rsp_payload;

  // Sequencer.
  gws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_cmd_i   (req_payload.cmd),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Stores, counters and result register.
  gws_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_payload),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_payload),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp_payload)
  );

endmodule
